// ===== hw/rtl/b64d_pkg.sv =====
// Shared types and codes for the base64url stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_INVALID = 2'd1;
	localparam logic [1:0] ERR_LONE    = 2'd2;

	localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SEXTET_DASH       = 6'd62;
	localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;

	typedef struct packed {
		logic [5:0] sextet;
		logic       bad;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] err_code;
		logic       stream_end;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/b64d_fifo.sv =====
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps

module b64d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/b64d_front.sv =====
// Front stage: accepts characters and classifies them into sextets.
`timescale 1ns / 1ps

module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_char,
	input  logic              last_char,
	output logic              full,
	output logic              item_push,
	output b64d_pkg::item_t   item,
	input  logic              item_full
);

	logic            valid_s1;
	b64d_pkg::item_t item_s1;
	logic            accept;

	function automatic b64d_pkg::item_t classify(input logic [7:0] c, input logic last);
		b64d_pkg::item_t r;
		r.last   = last;
		r.bad    = 1'b0;
		r.sextet = '0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r.sextet = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r.sextet = 6'(c - 8'h61) + b64d_pkg::SEXTET_LOWER_BASE;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.sextet = 6'(c - 8'h30) + b64d_pkg::SEXTET_DIGIT_BASE;
		end else if (c == 8'h2d) begin
			r.sextet = b64d_pkg::SEXTET_DASH;
		end else if (c == 8'h5f) begin
			r.sextet = b64d_pkg::SEXTET_UNDERSCORE;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	assign full      = valid_s1 && item_full;
	assign accept    = push && !full;
	assign item_push = valid_s1 && !item_full;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= classify(in_char, last_char);
		end
	end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back stage: tracks the group position and merges sextets into bytes.
`timescale 1ns / 1ps

module b64d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_empty,
	input  b64d_pkg::item_t   item,
	output logic              item_pop,
	output logic              res_push,
	output b64d_pkg::result_t res,
	input  logic              res_full
);

	logic [1:0] phase_q;
	logic [5:0] held_q;
	logic       discard_q;
	logic [1:0] phase_d;
	logic [5:0] held_d;
	logic       discard_d;
	logic       emit;

	assign item_pop = !item_empty && !res_full;
	assign res_push = item_pop && emit;

	always_comb begin
		phase_d        = phase_q;
		held_d         = held_q;
		discard_d      = discard_q;
		emit           = 1'b0;
		res.out_byte   = '0;
		res.err_code   = b64d_pkg::ERR_NONE;
		res.stream_end = item.last;
		if (discard_q) begin
			discard_d = !item.last;
			phase_d   = '0;
			held_d    = '0;
		end else if (item.bad) begin
			emit         = 1'b1;
			res.err_code = b64d_pkg::ERR_INVALID;
			phase_d      = '0;
			held_d       = '0;
			discard_d    = !item.last;
		end else begin
			case (phase_q)
				2'd0: begin
					if (item.last) begin
						emit         = 1'b1;
						res.err_code = b64d_pkg::ERR_LONE;
					end
					held_d  = item.sextet;
					phase_d = 2'd1;
				end
				2'd1: begin
					emit         = 1'b1;
					res.out_byte = {held_q, item.sextet[5:4]};
					held_d       = item.sextet;
					phase_d      = 2'd2;
				end
				2'd2: begin
					emit         = 1'b1;
					res.out_byte = {held_q[3:0], item.sextet[5:2]};
					held_d       = item.sextet;
					phase_d      = 2'd3;
				end
				default: begin
					emit         = 1'b1;
					res.out_byte = {held_q[1:0], item.sextet};
					held_d       = '0;
					phase_d      = 2'd0;
				end
			endcase
			if (item.last) begin
				phase_d = '0;
				held_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			held_q    <= '0;
			discard_q <= 1'b0;
		end else if (item_pop) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ===== hw/rtl/base64url_stream_decoder_unit.sv =====
// Each character passes the classify register, the item queue and the result queue in turn.
// Throughput: one character per cycle, limited by the single-entry classify stage.
// Stalls on the result side back up through the result queue, the item queue and the front.
// Reset: arst_n clears all queues and returns the decoder to group position zero.
`timescale 1ns / 1ps

module base64url_stream_decoder_unit #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       last_char,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [1:0] err_code,
	output logic       stream_end
);

	logic              fr_push;
	b64d_pkg::item_t   fr_item;
	logic              mid_full;
	logic              mid_empty;
	logic              mid_pop;
	b64d_pkg::item_t   mid_item;
	logic              bk_push;
	b64d_pkg::result_t bk_res;
	logic              out_full;
	b64d_pkg::result_t out_res;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_char   (in_char),
		.last_char (last_char),
		.full      (full),
		.item_push (fr_push),
		.item      (fr_item),
		.item_full (mid_full)
	);

	b64d_fifo #(
		.WIDTH (b64d_pkg::ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (mid_empty),
		.item       (mid_item),
		.item_pop   (mid_pop),
		.res_push   (bk_push),
		.res        (bk_res),
		.res_full   (out_full)
	);

	b64d_fifo #(
		.WIDTH (b64d_pkg::RESULT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_push),
		.wdata  (bk_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign out_byte   = out_res.out_byte;
	assign err_code   = out_res.err_code;
	assign stream_end = out_res.stream_end;

`ifndef SYNTHESIS
	a_err_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && err_code != b64d_pkg::ERR_NONE) |-> (out_byte == 8'd0))
		else $error("Error result carries a nonzero byte.");

	a_lone_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && err_code == b64d_pkg::ERR_LONE) |-> stream_end)
		else $error("Lone trailing character result without stream end.");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (err_code == b64d_pkg::ERR_NONE || err_code == b64d_pkg::ERR_INVALID
			|| err_code == b64d_pkg::ERR_LONE))
		else $error("Result carries an undefined error code.");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		bk_push |-> !out_full)
		else $error("Result written into a full result queue.");
`endif

endmodule

// ===== bench/base64url_stream_decoder_unit_tb.sv =====
// Self-checking testbench that streams characters into the base64url decoder and checks its bytes.
`timescale 1ns / 1ps

module base64url_stream_decoder_unit_tb;

	localparam int LIMIT           = 400000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int ITEMS_PER_PHASE = 260;
	localparam int NUM_PHASES      = 5;
	localparam int PRESSURE_PHASE  = 4;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_char = 8'd0;
	logic       last_char = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] err_code;
	logic       stream_end;

	enc_char_t         pending_chars[$];
	b64d_pkg::result_t expected_results[$];

	logic [1:0] grp_pos = 2'd0;
	logic [5:0] saved_sextet = 6'd0;
	logic       swallowing = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;

	int send_idle_by_phase[NUM_PHASES] = '{0, 79, 0, 27, 0};
	int recv_stall_by_phase[NUM_PHASES] = '{0, 0, 79, 27, 0};

	base64url_stream_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_char(in_char),
		.last_char(last_char),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.err_code(err_code),
		.stream_end(stream_end)
	);

	always #5 clk = ~clk;

	// Returns {valid, sextet} for one character.
	function automatic logic [6:0] sextet_of(logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return {1'b1, 6'(c - "A")};
		end
		if (c >= "a" && c <= "z") begin
			return {1'b1, 6'(c - "a") + b64d_pkg::SEXTET_LOWER_BASE};
		end
		if (c >= "0" && c <= "9") begin
			return {1'b1, 6'(c - "0") + b64d_pkg::SEXTET_DIGIT_BASE};
		end
		if (c == "-") begin
			return {1'b1, b64d_pkg::SEXTET_DASH};
		end
		if (c == "_") begin
			return {1'b1, b64d_pkg::SEXTET_UNDERSCORE};
		end
		return 7'd0;
	endfunction

	function automatic void restart_stream();
		grp_pos = 2'd0;
		saved_sextet = 6'd0;
		swallowing = 1'b0;
	endfunction

	task automatic decode_char(logic [7:0] c, logic last);
		logic [6:0] lk;
		logic [7:0] b;
		lk = sextet_of(c);
		if (swallowing) begin
			if (last) begin
				restart_stream();
			end
			return;
		end
		if (!lk[6]) begin
			expected_results.push_back('{8'd0, b64d_pkg::ERR_INVALID, last});
			restart_stream();
			swallowing = !last;
			return;
		end
		case (grp_pos)
			2'd0: begin
				if (last) begin
					expected_results.push_back('{8'd0, b64d_pkg::ERR_LONE, 1'b1});
					restart_stream();
				end else begin
					saved_sextet = lk[5:0];
					grp_pos = 2'd1;
				end
				return;
			end
			2'd1: begin
				b = {saved_sextet, lk[5:4]};
				saved_sextet = lk[5:0];
				grp_pos = 2'd2;
			end
			2'd2: begin
				b = {saved_sextet[3:0], lk[5:2]};
				saved_sextet = lk[5:0];
				grp_pos = 2'd3;
			end
			default: begin
				b = {saved_sextet[1:0], lk[5:0]};
				saved_sextet = 6'd0;
				grp_pos = 2'd0;
			end
		endcase
		expected_results.push_back('{b, b64d_pkg::ERR_NONE, last});
		if (last) begin
			restart_stream();
		end
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			pending_chars.push_back('{s[i], i == s.len() - 1});
		end
	endtask

	// Mostly well-formed streams with random content, some broken by a stray byte, some pure noise.
	task automatic add_random_streams(int target);
		int counted;
		int len;
		bit noise;
		logic [5:0] v;
		logic [7:0] c;
		counted = 0;
		while (counted < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			noise = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++) begin
				if (noise || $urandom_range(0, 99) < 3) begin
					c = 8'($urandom_range(0, 255));
				end else begin
					v = 6'($urandom_range(0, 63));
					if (v < b64d_pkg::SEXTET_LOWER_BASE) begin
						c = "A" + 8'(v);
					end else if (v < b64d_pkg::SEXTET_DIGIT_BASE) begin
						c = "a" + 8'(v - b64d_pkg::SEXTET_LOWER_BASE);
					end else if (v < b64d_pkg::SEXTET_DASH) begin
						c = "0" + 8'(v - b64d_pkg::SEXTET_DIGIT_BASE);
					end else if (v == b64d_pkg::SEXTET_DASH) begin
						c = "-";
					end else begin
						c = "_";
					end
				end
				counted++;
				pending_chars.push_back('{c, i == len - 1});
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				decode_char(pending_chars[0].ch, pending_chars[0].last);
				void'(pending_chars.pop_front());
			end
			if (push && full) begin
				push <= 1'b1;
			end else if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				in_char <= pending_chars[0].ch;
				last_char <= pending_chars[0].last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		b64d_pkg::result_t exp_r;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected transaction: byte %h err %0d end %0d",
							$realtime, out_byte, err_code, stream_end);
					end
				end else begin
					exp_r = expected_results.pop_front();
					if (out_byte !== exp_r.out_byte || err_code !== exp_r.err_code ||
						stream_end !== exp_r.stream_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected byte %h err %0d end %0d,",
								$realtime, exp_r.out_byte, exp_r.err_code,
								exp_r.stream_end,
								" got byte %h err %0d end %0d",
								out_byte, err_code, stream_end);
						end
					end
				end
			end
			pop <= !(hold_armed && !hold_done) && $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("base64url_stream_decoder_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		add_text("TWFu");
		add_text("-_09");
		add_text("azZ_");
		add_text("A");
		add_text("=");
		add_text("AB=CD");
		pending_chars.push_back('{8'hFF, 1'b0});
		pending_chars.push_back('{8'h00, 1'b1});
		add_text("AAAAB");
		pending_chars.push_back('{"A", 1'b0});
		pending_chars.push_back('{"B", 1'b0});
		pending_chars.push_back('{8'h80, 1'b1});
		add_random_streams(ITEMS_PER_PHASE);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				@(negedge clk);
				send_idle_pct = send_idle_by_phase[phase];
				recv_stall_pct = recv_stall_by_phase[phase];
				if (phase == PRESSURE_PHASE) begin
					hold_armed = 1'b1;
				end
				add_random_streams(ITEMS_PER_PHASE);
			end
			while (pending_chars.size() != 0 || expected_results.size() != 0) begin
				@(posedge clk);
			end
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("base64url_stream_decoder_unit_tb OK");
		end else begin
			$display("base64url_stream_decoder_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
